/* rtl/vstc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vstc_pkg
// Shared types and constants for the virtual system timer compare block.
// ----------------------------------------------------------------------------
package vstc_pkg;

  // Number of compare channels.
  localparam int CHANNELS = 4;

  // Width of a channel select.
  localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  // Status vector padded to at least the four reported bits.
  localparam int STAT_PAD = (CHANNELS > 4) ? CHANNELS : 4;

  localparam logic [31:0] LOW_ONES = 32'hffff_ffff;

  // Operation codes.
  typedef enum logic [1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_ENTER = 2'd2,
    OP_LEAVE = 2'd3
  } op_t;

  // Register indexes.
  localparam logic [2:0] REG_CS       = 3'd0;
  localparam logic [2:0] REG_CNT_LO   = 3'd1;
  localparam logic [2:0] REG_CNT_HI   = 3'd2;
  localparam logic [2:0] REG_CMP_BASE = 3'd3;

  // Result of the nearest-compare search on a guest enter.
  typedef struct packed {
    logic [CHANNELS-1:0] matched;
    logic [31:0]         delta;
    logic                found;
  } vstc_near_t;

endpackage

/* rtl/virtual_system_timer_compare.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// virtual_system_timer_compare
// Four-channel system timer compare over a virtual count.
// ----------------------------------------------------------------------------
// Each input transaction carries an operation (read, write, guest enter or
// guest leave), a register index, write data and the current physical time.
// Every input transaction produces exactly one result transaction with the
// read data, the channel match status, and on an enter the distance to the
// nearest future compare.
// The input transaction is captured in an input register and worked on there;
// the result is registered. One transaction per cycle is sustained while the
// receiver takes results; the figure is set by the single pass of subtract,
// compare and minimum logic between the input register and the result
// register, against state that is updated at the same edge.
// When the receiver stalls, the result register holds and the input register
// still takes one more transaction; ready falls only when both are full.
// Reset clears the offset, the stored exit time, the match status and all
// compare values; no clearing pass is needed and the block accepts input as
// soon as reset is released.
// ----------------------------------------------------------------------------
module virtual_system_timer_compare
  import vstc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  op,
  input  logic [2:0]  reg_index,
  input  logic [31:0] write_data,
  input  logic [63:0] now_physical,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] read_data,
  output logic [3:0]  status_bits,
  output logic        next_valid,
  output logic [31:0] next_delta
);

  // Input register.
  logic        s1_valid;
  op_t         s1_op;
  logic [2:0]  s1_idx;
  logic [31:0] s1_data;
  logic [63:0] s1_now;

  // Timer state. last_exit_time is the physical time at the last leave; the
  // virtual count seen on an enter is that time less the offset held so far.
  logic [63:0]               pause_offset;
  logic [63:0]               last_exit_time;
  logic [CHANNELS-1:0]       match_status;
  logic [CHANNELS-1:0]       match_status_next;
  logic [CHANNELS-1:0][31:0] compare_low;
  logic [CHANNELS-1:0][63:0] compare_full;

  logic        s2_load;
  logic [63:0] virt;
  logic [63:0] enter_virt;
  logic [2:0]  cmp_sel;
  logic        cmp_hit;
  logic [CH_W-1:0] cmp_ch;
  logic        cmp_carry;
  logic [31:0] rd_value;
  logic [STAT_PAD-1:0] stat_ext;
  vstc_near_t  near;

  // Handshake: the result register frees up when empty or taken.
  assign s2_load  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || s2_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      s1_op   <= op_t'(op);
      s1_idx  <= reg_index;
      s1_data <= write_data;
      s1_now  <= now_physical;
    end
  end

  // Virtual count and compare channel decode.
  assign virt       = s1_now - pause_offset;
  assign enter_virt = last_exit_time - pause_offset;
  assign cmp_sel = s1_idx - REG_CMP_BASE;
  assign cmp_hit = (s1_idx >= REG_CMP_BASE) && (4'(cmp_sel) < 4'(CHANNELS));
  assign cmp_ch  = cmp_sel[CH_W-1:0];
  // The upper half steps on when the new low half is not ahead of the count.
  assign cmp_carry = !(s1_data > virt[31:0]);

  vstc_nearest u_nearest (
    .virt         (enter_virt),
    .compare_full (compare_full),
    .near         (near)
  );

  // Register read mux.
  always_comb begin
    rd_value = 32'd0;
    if (s1_idx == REG_CS) begin
      rd_value = 32'(match_status);
    end else if (s1_idx == REG_CNT_LO) begin
      rd_value = virt[31:0];
    end else if (s1_idx == REG_CNT_HI) begin
      rd_value = virt[63:32];
    end else if (cmp_hit) begin
      rd_value = compare_low[cmp_ch];
    end
  end

  // Next match status.
  always_comb begin
    match_status_next = match_status;
    case (s1_op)
      OP_WRITE: begin
        if (s1_idx == REG_CS) begin
          match_status_next = match_status & ~s1_data[CHANNELS-1:0];
        end
      end
      OP_ENTER: begin
        match_status_next = match_status | near.matched;
      end
      default: begin
        match_status_next = match_status;
      end
    endcase
  end

  assign stat_ext = STAT_PAD'(match_status_next);

  // State update and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid      <= 1'b0;
      pause_offset   <= 64'd0;
      last_exit_time <= 64'd0;
      match_status   <= '0;
      compare_low    <= '0;
      compare_full   <= '0;
    end else begin
      if (s2_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (s2_load) begin
        match_status <= match_status_next;
        case (s1_op)
          OP_WRITE: begin
            for (int c = 0; c < CHANNELS; c++) begin
              if (cmp_hit && (cmp_ch == CH_W'(c))) begin
                compare_low[c]  <= s1_data;
                compare_full[c] <= {virt[63:32] + 32'(cmp_carry), s1_data};
              end
            end
          end
          OP_ENTER: begin
            // Offset grows by the physical time spent since the last leave.
            pause_offset <= s1_now - enter_virt;
          end
          OP_LEAVE: begin
            last_exit_time <= s1_now;
          end
          default: begin
          end
        endcase
      end
    end
    if (s2_load) begin
      read_data   <= (s1_op == OP_READ) ? rd_value : 32'd0;
      status_bits <= stat_ext[3:0];
      next_delta  <= (s1_op == OP_ENTER) ? near.delta : LOW_ONES;
      next_valid  <= (s1_op == OP_ENTER) && near.found;
    end
  end

  // A waiting input transaction is held while the result register is full.
  assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s2_load |=> s1_valid && $stable(s1_now) && $stable(s1_op))
    else $error("input register changed while stalled");

  // A leave records the physical time it saw.
  assert property (@(posedge clk) disable iff (rst)
    s2_load && (s1_op == OP_LEAVE) |=> last_exit_time == $past(s1_now))
    else $error("exit time not recorded on leave");

  // An enter moves the offset so that the virtual count resumes where it left.
  assert property (@(posedge clk) disable iff (rst)
    s2_load && (s1_op == OP_ENTER) |=>
      pause_offset == $past(s1_now) - $past(enter_virt))
    else $error("offset not updated on enter");

  // A reported future compare never carries the all-ones distance.
  assert property (@(posedge clk) disable iff (rst)
    s2_load && (s1_op == OP_ENTER) && near.found |=>
      next_valid && (next_delta != LOW_ONES))
    else $error("nearest compare reported with invalid distance");

endmodule

/* rtl/vstc_nearest.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vstc_nearest
// Compares every channel against the virtual count on a guest enter, flags the
// channels reached and picks the smallest distance to a compare ahead within 32 bits.
// ----------------------------------------------------------------------------
module vstc_nearest
  import vstc_pkg::*;
(
  input  logic [63:0]               virt,
  input  logic [CHANNELS-1:0][63:0] compare_full,
  output vstc_near_t                near
);

  logic [CHANNELS-1:0][63:0] diff;
  logic [CHANNELS-1:0]       matched;
  logic [CHANNELS-1:0]       usable;
  logic [31:0]               best;

  // Per-channel distance and match flag.
  always_comb begin
    for (int c = 0; c < CHANNELS; c++) begin
      diff[c]    = compare_full[c] - virt;
      matched[c] = (virt >= compare_full[c]);
      usable[c]  = !matched[c] && (diff[c][63:32] == 32'd0) &&
                   (diff[c][31:0] != LOW_ONES);
    end
  end

  // Running minimum over the usable distances.
  always_comb begin
    best = LOW_ONES;
    for (int c = 0; c < CHANNELS; c++) begin
      if (usable[c] && (diff[c][31:0] < best)) begin
        best = diff[c][31:0];
      end
    end
  end

  assign near.matched = matched;
  assign near.delta   = best;
  assign near.found   = (best != LOW_ONES);

endmodule
